// ----- rtl/core/lpmd_pkg.sv -----
// Shared types, constants and the field selector of the message deframer.
package lpmd_pkg;

    localparam int unsigned HDR_BYTES       = 8;
    localparam int unsigned SHORT_FIELDS    = 4;
    localparam int unsigned LPMD_QUEUE_DEPTH = 2;

    // Stream widths
    localparam int unsigned TDATA_W = 48;
    localparam int unsigned TUSER_W = 4;

    // Record kinds
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Field tags
    localparam logic [2:0] FIELD_TO      = 3'd0;
    localparam logic [2:0] FIELD_FROM    = 3'd1;
    localparam logic [2:0] FIELD_THREAD  = 3'd2;
    localparam logic [2:0] FIELD_SUBJECT = 3'd3;
    localparam logic [2:0] FIELD_BODY    = 3'd4;

    // One result record
    typedef struct packed {
        logic        record_kind;
        logic [2:0]  field_tag;
        logic [7:0]  payload_byte;
        logic [32:0] total_length;
        logic        field_end;
        logic        message_end;
    } lpmd_rec_t;

    typedef logic [7:0] short_len_t [SHORT_FIELDS];

    // Field selection result
    typedef struct packed {
        logic [2:0]  field;
        logic [31:0] remaining;
    } lpmd_sel_t;

    // First field at index >= start with a nonzero length; zeros if none.
    function automatic lpmd_sel_t lpmd_select(input logic [2:0] start,
                                              input short_len_t lens,
                                              input logic [31:0] body);
        lpmd_sel_t   sel;
        logic        found;
        logic [31:0] len;
        sel   = '0;
        found = 1'b0;
        for (int f = 0; f <= int'(FIELD_BODY); f++) begin
            if (f < int'(SHORT_FIELDS)) begin
                len = {24'd0, lens[f]};
            end else begin
                len = body;
            end
            if (!found && (3'(f) >= start) && (len != 32'd0)) begin
                found         = 1'b1;
                sel.field     = 3'(f);
                sel.remaining = len;
            end
        end
        return sel;
    endfunction

endpackage

// ----- rtl/core/length_prefixed_message_deframer_unit.sv -----
// Length-prefixed message deframer.
// Input stream (s_): one raw byte per item in s_tdata[7:0]. Each message is
// an 8-byte header (four one-byte field lengths, then a big-endian 32-bit
// body length) followed by the to, from, thread, subject and body fields.
// Output stream (m_): one record per header and one per payload byte.
// Header bytes one to seven produce nothing; the eighth yields a header
// record with the total payload length, tlast set if that length is zero.
// Payload records carry the byte, its field tag and an end-of-field flag;
// tlast marks the last byte of the message. Empty fields are skipped.
// Throughput: one item per cycle in both directions while m_tready stays high
// and the queue has room; all counters and the next-field search are
// combinational in the front end. A record enters the queue at the edge that
// accepts its byte and moves from the queue head into the output register,
// which drives m_, once that register is empty or being read.
// Backpressure: a stalled receiver fills the output register and the queue
// (QUEUE_DEPTH entries); s_tready drops only when the queue is full.
// Reset (aresetn low, synchronous) empties the queue and output register and
// returns the front end to expecting the first header byte.
module length_prefixed_message_deframer_unit import lpmd_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = LPMD_QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [7:0] payload_byte, [40:8] total_length,
                                          // [41] field_end, [47:42] zero
    output logic [TUSER_W-1:0] m_tuser,   // [0] record_kind, [3:1] field_tag
    output logic               m_tlast,   // message_end
    output logic               m_tvalid,
    input  logic               m_tready
);

    lpmd_rec_t front_rec, queue_rec;
    logic      front_valid, front_ready;
    logic      queue_valid, back_ready;

    lpmd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_byte   (s_tdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .rec       (front_rec),
        .rec_valid (front_valid),
        .rec_ready (front_ready)
    );

    lpmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_rec   (front_rec),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_rec   (queue_rec),
        .rd_valid (queue_valid),
        .rd_ready (back_ready)
    );

    lpmd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec       (queue_rec),
        .rec_valid (queue_valid),
        .rec_ready (back_ready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

endmodule

// ----- rtl/core/lpmd_front.sv -----
// Front end: takes stream bytes, tracks header and field counters, builds records.
module lpmd_front import lpmd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] in_byte,
    input  logic       in_valid,
    output logic       in_ready,
    output lpmd_rec_t  rec,
    output logic       rec_valid,
    input  logic       rec_ready
);

    logic [3:0]  hdr_cnt_reg,   hdr_cnt_next;
    short_len_t  short_len_reg, short_len_next;
    logic [31:0] body_len_reg,  body_len_next;
    logic [2:0]  cur_field_reg, cur_field_next;
    logic [31:0] field_rem_reg, field_rem_next;
    logic [32:0] msg_rem_reg,   msg_rem_next;

    logic        accept;
    logic [32:0] total;
    logic [31:0] field_dec;
    logic [32:0] msg_dec;
    lpmd_sel_t   sel;

    assign in_ready = rec_ready;
    assign accept   = in_valid && rec_ready;

    // Classify the byte and compute next counters
    always_comb begin
        hdr_cnt_next   = hdr_cnt_reg;
        short_len_next = short_len_reg;
        body_len_next  = body_len_reg;
        cur_field_next = cur_field_reg;
        field_rem_next = field_rem_reg;
        msg_rem_next   = msg_rem_reg;
        rec            = '0;
        rec_valid      = 1'b0;
        total          = '0;
        sel            = '0;
        field_dec      = field_rem_reg - 32'd1;
        msg_dec        = msg_rem_reg - 33'd1;

        if (accept) begin
            if (hdr_cnt_reg < 4'(HDR_BYTES)) begin
                // header byte
                if (hdr_cnt_reg < 4'(SHORT_FIELDS)) begin
                    short_len_next[hdr_cnt_reg[1:0]] = in_byte;
                end else begin
                    body_len_next = {body_len_reg[23:0], in_byte};
                end
                hdr_cnt_next = hdr_cnt_reg + 4'd1;
                if (hdr_cnt_reg == 4'(HDR_BYTES - 1)) begin
                    total = {25'd0, short_len_reg[0]} + {25'd0, short_len_reg[1]}
                          + {25'd0, short_len_reg[2]} + {25'd0, short_len_reg[3]}
                          + {1'b0, body_len_next};
                    rec_valid        = 1'b1;
                    rec.record_kind  = KIND_HEADER;
                    rec.total_length = total;
                    rec.message_end  = (total == 33'd0);
                    if (total == 33'd0) begin
                        hdr_cnt_next   = '0;
                        cur_field_next = FIELD_TO;
                        field_rem_next = '0;
                        msg_rem_next   = '0;
                    end else begin
                        sel            = lpmd_select(FIELD_TO, short_len_reg, body_len_next);
                        msg_rem_next   = total;
                        cur_field_next = sel.field;
                        field_rem_next = sel.remaining;
                    end
                end
            end else begin
                // payload byte
                rec_valid        = 1'b1;
                rec.record_kind  = KIND_PAYLOAD;
                rec.field_tag    = cur_field_reg;
                rec.payload_byte = in_byte;
                rec.field_end    = (field_dec == 32'd0);
                rec.message_end  = (msg_dec == 33'd0);
                msg_rem_next     = msg_dec;
                field_rem_next   = field_dec;
                if (msg_dec == 33'd0) begin
                    hdr_cnt_next   = '0;
                    cur_field_next = FIELD_TO;
                    field_rem_next = '0;
                end else if (field_dec == 32'd0) begin
                    sel = lpmd_select(cur_field_reg + 3'd1, short_len_reg, body_len_reg);
                    cur_field_next = sel.field;
                    field_rem_next = sel.remaining;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_cnt_reg   <= '0;
            short_len_reg <= '{default: '0};
            body_len_reg  <= '0;
            cur_field_reg <= FIELD_TO;
            field_rem_reg <= '0;
            msg_rem_reg   <= '0;
        end else begin
            hdr_cnt_reg   <= hdr_cnt_next;
            short_len_reg <= short_len_next;
            body_len_reg  <= body_len_next;
            cur_field_reg <= cur_field_next;
            field_rem_reg <= field_rem_next;
            msg_rem_reg   <= msg_rem_next;
        end
    end

endmodule

// ----- rtl/core/lpmd_queue.sv -----
// Short record queue between the front end and the output stage.
module lpmd_queue import lpmd_pkg::*; #(
    parameter int unsigned DEPTH = LPMD_QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  lpmd_rec_t wr_rec,
    input  logic      wr_valid,
    output logic      wr_ready,
    output lpmd_rec_t rd_rec,
    output logic      rd_valid,
    input  logic      rd_ready
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    lpmd_rec_t       mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            push, pop;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_rec   = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

endmodule

// ----- rtl/core/lpmd_back.sv -----
// Output stage: holds one record and drives the result stream.
module lpmd_back import lpmd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  lpmd_rec_t          rec,
    input  logic               rec_valid,
    output logic               rec_ready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic [TUSER_W-1:0] m_tuser,
    output logic               m_tlast,
    output logic               m_tvalid,
    input  logic               m_tready
);

    lpmd_rec_t out_rec_reg;
    logic      out_valid_reg;

    assign rec_ready = !out_valid_reg || m_tready;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (rec_ready) begin
            out_valid_reg <= rec_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_ready && rec_valid) begin
            out_rec_reg <= rec;
        end
    end

    // Pack the record onto the stream
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_rec_reg.field_end, out_rec_reg.total_length,
                       out_rec_reg.payload_byte};
    assign m_tuser  = {out_rec_reg.field_tag, out_rec_reg.record_kind};
    assign m_tlast  = out_rec_reg.message_end;

endmodule

// ----- sim/length_prefixed_message_deframer_unit_tb.sv -----
// Self-checking testbench for the length-prefixed message deframer.
`timescale 1ns / 1ps

module length_prefixed_message_deframer_unit_tb import lpmd_pkg::*; ();

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_ITEMS = 950;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned HOLD_AT_ITEM = 300;
    localparam int unsigned MAX_PRINTED = 20;

    // Predicts deframer records from accepted bytes and checks them in order
    class deframer_scoreboard;
        logic [3:0]  hdr_seen;
        logic [7:0]  short_len [SHORT_FIELDS];
        logic [31:0] body_len;
        logic [2:0]  cur_field;
        logic [31:0] field_left;
        logic [32:0] msg_left;
        lpmd_rec_t   expected_recs [$];
        int          errors;

        function new();
            hdr_seen   = '0;
            body_len   = '0;
            cur_field  = FIELD_TO;
            field_left = '0;
            msg_left   = '0;
            errors     = 0;
            foreach (short_len[i]) short_len[i] = '0;
        endfunction

        function logic [31:0] field_len(int f);
            if (f < int'(SHORT_FIELDS)) return {24'd0, short_len[f]};
            if (f == int'(FIELD_BODY)) return body_len;
            return '0;
        endfunction

        // Move to the first nonempty field at or after start
        function void pick_field(int start);
            cur_field  = FIELD_TO;
            field_left = '0;
            for (int f = start; f <= int'(FIELD_BODY); f++) begin
                if (field_len(f) != 0) begin
                    cur_field  = 3'(f);
                    field_left = field_len(f);
                    return;
                end
            end
        endfunction

        function void note_byte(logic [7:0] b);
            lpmd_rec_t   rec;
            logic [32:0] total;
            rec = '0;
            // header phase: collect lengths, record on the eighth byte
            if (hdr_seen < 4'(HDR_BYTES)) begin
                if (hdr_seen < 4'(SHORT_FIELDS)) short_len[hdr_seen[1:0]] = b;
                else body_len = {body_len[23:0], b};
                hdr_seen++;
                if (hdr_seen < 4'(HDR_BYTES)) return;
                total = {1'b0, body_len};
                foreach (short_len[i]) total += {25'd0, short_len[i]};
                rec.record_kind  = KIND_HEADER;
                rec.field_tag    = FIELD_TO;
                rec.total_length = total;
                rec.message_end  = (total == 0);
                if (total == 0) begin
                    hdr_seen   = '0;
                    cur_field  = FIELD_TO;
                    field_left = '0;
                    msg_left   = '0;
                end else begin
                    msg_left = total;
                    pick_field(0);
                end
                expected_recs = {expected_recs, rec};
                return;
            end
            // payload byte
            field_left--;
            msg_left--;
            rec.record_kind  = KIND_PAYLOAD;
            rec.field_tag    = cur_field;
            rec.payload_byte = b;
            rec.field_end    = (field_left == 0);
            rec.message_end  = (msg_left == 0);
            expected_recs = {expected_recs, rec};
            if (msg_left == 0) begin
                hdr_seen   = '0;
                cur_field  = FIELD_TO;
                field_left = '0;
            end else if (field_left == 0) begin
                pick_field(int'(cur_field) + 1);
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check_record(logic [TDATA_W-1:0] data, logic [TUSER_W-1:0] user,
                          logic last);
            lpmd_rec_t exp_rec;
            if (expected_recs.size() == 0) begin
                report($sformatf("unexpected record data=%h user=%h last=%b",
                                 data, user, last));
                return;
            end
            exp_rec = expected_recs[0];
            expected_recs.delete(0);
            if (user[0] !== exp_rec.record_kind)
                report($sformatf("record_kind %b, expected %b", user[0],
                                 exp_rec.record_kind));
            if (user[3:1] !== exp_rec.field_tag)
                report($sformatf("field_tag %0d, expected %0d", user[3:1],
                                 exp_rec.field_tag));
            if (data[7:0] !== exp_rec.payload_byte)
                report($sformatf("payload_byte %h, expected %h", data[7:0],
                                 exp_rec.payload_byte));
            if (data[40:8] !== exp_rec.total_length)
                report($sformatf("total_length %h, expected %h", data[40:8],
                                 exp_rec.total_length));
            if (data[41] !== exp_rec.field_end)
                report($sformatf("field_end %b, expected %b", data[41],
                                 exp_rec.field_end));
            if (last !== exp_rec.message_end)
                report($sformatf("message_end %b, expected %b", last,
                                 exp_rec.message_end));
        endtask

        function int pending();
            return expected_recs.size();
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic [7:0]         s_tdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [TUSER_W-1:0] m_tuser;
    logic               m_tlast;
    logic               m_tvalid;
    logic               m_tready;

    deframer_scoreboard sb = new();
    int unsigned        cycle_count = 0;
    int unsigned        sent_items = 0;
    bit                 no_idle = 1'b0;

    length_prefixed_message_deframer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("length_prefixed_message_deframer_unit test failed");
            $finish;
        end
    end

    // Monitor: check results first, then note the byte taken at this edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_record(m_tdata, m_tuser, m_tlast);
            if (s_tvalid && s_tready) sb.note_byte(s_tdata);
        end
    end

    // Receiver: random stalls, one long hold-off once traffic is flowing
    initial begin
        int unsigned hold_left;
        bit          hold_done;
        m_tready  = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && sent_items >= HOLD_AT_ITEM) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= 33);
            end
        end
    end

    // Offer one byte, with random idle cycles ahead of it; returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while (!no_idle && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
        @(negedge aclk);
    endtask

    task automatic send_header(input logic [7:0] l_to, input logic [7:0] l_from,
                               input logic [7:0] l_thread, input logic [7:0] l_subject,
                               input logic [31:0] l_body);
        send_byte(l_to);
        send_byte(l_from);
        send_byte(l_thread);
        send_byte(l_subject);
        send_byte(l_body[31:24]);
        send_byte(l_body[23:16]);
        send_byte(l_body[15:8]);
        send_byte(l_body[7:0]);
    endtask

    // Full message with random payload content
    task automatic send_message(input logic [7:0] l_to, input logic [7:0] l_from,
                                input logic [7:0] l_thread, input logic [7:0] l_subject,
                                input logic [31:0] l_body);
        int unsigned total;
        total = l_to + l_from + l_thread + l_subject + l_body;
        send_header(l_to, l_from, l_thread, l_subject, l_body);
        for (int unsigned i = 0; i < total; i++) send_byte(8'($urandom_range(255)));
    endtask

    // Mostly short or empty fields, now and then a long one
    function automatic logic [7:0] pick_short_len(bit allow_long);
        int unsigned r;
        r = $urandom_range(99);
        if (allow_long && r < 3) return 8'($urandom_range(250, 255));
        if (r < 35) return 8'd0;
        if (r < 90) return 8'($urandom_range(1, 4));
        return 8'($urandom_range(5, 12));
    endfunction

    initial begin
        logic [7:0]  lens [SHORT_FIELDS];
        logic [31:0] body;
        bit          allow_long;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty message, then one byte in each field but thread
        send_header(8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
        send_header(8'd1, 8'd1, 8'd0, 8'd1, 32'd1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);

        // Random well-formed messages; a stretch in the middle runs without idling
        while (sent_items < RANDOM_ITEMS) begin
            no_idle    = (sent_items >= 450) && (sent_items < 600);
            allow_long = ($urandom_range(39) == 0);
            foreach (lens[i]) lens[i] = pick_short_len(allow_long);
            case ($urandom_range(9))
                0: body = 32'd0;
                1: body = 32'($urandom_range(200, 300));
                default: body = 32'($urandom_range(1, 20));
            endcase
            send_message(lens[0], lens[1], lens[2], lens[3], body);
        end
        no_idle = 1'b0;

        // Largest header: total length overflows 32 bits; message left open
        send_header(8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        repeat (3) send_byte(8'($urandom_range(255)));
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("length_prefixed_message_deframer_unit test passed");
        end else begin
            $display("length_prefixed_message_deframer_unit test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/lpmd_pkg.sv
rtl/core/lpmd_front.sv
rtl/core/lpmd_queue.sv
rtl/core/lpmd_back.sv
rtl/core/length_prefixed_message_deframer_unit.sv
sim/length_prefixed_message_deframer_unit_tb.sv
